// ----- src/fth_pkg.sv -----
// Shared constants and types for the fat tree route hop block.
// Used by every module under src except fth_div_pipe; no dependencies.
package fth_pkg;

  localparam int MAX_ARITY_DEF = 64;
  localparam int RESET_ARITY   = 4;

  localparam int HOST_W      = 16;
  localparam int ARITY_CFG_W = 7;
  localparam int SWITCH_W    = 13;
  localparam int HOP_IDX_W   = 3;
  localparam int LAYER_W     = 2;
  localparam int MAX_HOPS    = 5;

  localparam logic [LAYER_W-1:0] LAYER_RACK = 2'd0;
  localparam logic [LAYER_W-1:0] LAYER_AGG  = 2'd1;
  localparam logic [LAYER_W-1:0] LAYER_CORE = 2'd2;

  // One complete route, ready to be sent out a hop at a time.
  typedef struct packed {
    logic [MAX_HOPS-1:0][SWITCH_W-1:0] sw;
    logic [MAX_HOPS-1:0][LAYER_W-1:0]  layer;
    logic [HOP_IDX_W-1:0]              last_idx;
    logic                              bad;
  } route_t;

  typedef struct packed {
    logic [SWITCH_W-1:0]  switch_number;
    logic [HOP_IDX_W-1:0] hop_index;
    logic [LAYER_W-1:0]   hop_layer;
    logic                 last_hop;
    logic                 bad_host;
  } hop_t;

endpackage

// ----- src/fth_cfg.sv -----
// Arity register and the tree sizes derived from it.
// Depends on fth_pkg.
module fth_cfg #(
  parameter int MAX_ARITY = fth_pkg::MAX_ARITY_DEF,
  localparam int KW   = $clog2(MAX_ARITY + 1),
  localparam int HW   = $clog2(MAX_ARITY / 2 + 1),
  localparam int PPW  = 2 * HW,
  localparam int KSQW = 2 * KW,
  localparam int HSW  = KW + PPW
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [fth_pkg::ARITY_CFG_W-1:0]    cfg_data,
  output logic [KW-1:0]                      k,
  output logic [HW-1:0]                      half,
  output logic [PPW-1:0]                     per_pod,
  output logic [KSQW-1:0]                    ksq,
  output logic [HSW-1:0]                     hosts,
  output logic                               settling
);

  localparam int CMPW = (KW > fth_pkg::ARITY_CFG_W) ? KW : fth_pkg::ARITY_CFG_W;
  localparam logic [CMPW-1:0] TOP = CMPW'(MAX_ARITY - (MAX_ARITY % 2));
  localparam int RST_HALF = fth_pkg::RESET_ARITY / 2;

  logic [CMPW-1:0] raw;
  logic [CMPW-1:0] clamp;
  logic [KW-1:0]   k_w;
  logic [HW-1:0]   half_w;

  // Drop the low bit, then clamp into the supported range.
  assign raw = CMPW'({cfg_data[fth_pkg::ARITY_CFG_W-1:1], 1'b0});

  always_comb begin
    clamp = raw;
    if (raw < CMPW'(2)) begin
      clamp = CMPW'(2);
    end else if (raw > TOP) begin
      clamp = TOP;
    end
  end

  assign k_w    = clamp[KW-1:0];
  assign half_w = HW'(k_w >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= KW'(fth_pkg::RESET_ARITY);
      half     <= HW'(RST_HALF);
      per_pod  <= PPW'(RST_HALF * RST_HALF);
      ksq      <= KSQW'(fth_pkg::RESET_ARITY * fth_pkg::RESET_ARITY);
      hosts    <= HSW'(fth_pkg::RESET_ARITY * RST_HALF * RST_HALF);
      settling <= 1'b0;
    end else begin
      settling <= cfg_we;
      if (cfg_we) begin
        k       <= k_w;
        half    <= half_w;
        per_pod <= PPW'(half_w) * PPW'(half_w);
        ksq     <= KSQW'(k_w) * KSQW'(k_w);
      end
      // Host count needs the new per-pod size, so it is updated in the cycle after it.
      if (settling) begin
        hosts <= HSW'(per_pod) * HSW'(k);
      end
    end
  end

endmodule

// ----- src/fth_div_pipe.sv -----
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Both lanes share the divisor; a sideband word travels with each item.
module fth_div_pipe #(
  parameter int NW = 16,
  parameter int DW = 12,
  parameter int QW = 6,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num [2],
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo [2],
  output logic [DW-1:0] out_rem [2],
  output logic [SW-1:0] out_side
);

  localparam int CW = (DW + QW > NW) ? DW + QW : NW;

  logic          vld  [QW+1];
  logic [NW-1:0] rem  [QW+1][2];
  logic [QW-1:0] quo  [QW+1][2];
  logic [SW-1:0] side [QW+1];

  assign vld[0]    = in_valid;
  assign rem[0][0] = in_num[0];
  assign rem[0][1] = in_num[1];
  assign quo[0][0] = '0;
  assign quo[0][1] = '0;
  assign side[0]   = in_side;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int BIT = QW - 1 - s;
    logic [CW-1:0] trial;
    logic [NW-1:0] rem_n [2];
    logic [QW-1:0] quo_n [2];

    assign trial = CW'(divisor) << BIT;

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic take;
      assign take     = CW'(rem[s][l]) >= trial;
      assign rem_n[l] = take ? NW'(CW'(rem[s][l]) - trial) : rem[s][l];
      assign quo_n[l] = quo[s][l] | (QW'(take) << BIT);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        rem[s+1]  <= rem_n;
        quo[s+1]  <= quo_n;
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid  = vld[QW];
  assign out_quo[0] = quo[QW][0];
  assign out_quo[1] = quo[QW][1];
  assign out_rem[0] = DW'(rem[QW][0]);
  assign out_rem[1] = DW'(rem[QW][1]);
  assign out_side   = side[QW];

endmodule

// ----- src/fth_route.sv -----
// Three stages that turn pod, rack and position numbers into switch numbers.
// Depends on fth_pkg for route_t and the layer codes.
module fth_route #(
  parameter int MAX_ARITY = fth_pkg::MAX_ARITY_DEF,
  localparam int KW   = $clog2(MAX_ARITY + 1),
  localparam int HW   = $clog2(MAX_ARITY / 2 + 1),
  localparam int KSQW = 2 * KW,
  localparam int QA   = $clog2(MAX_ARITY),
  localparam int QB   = $clog2(MAX_ARITY / 2)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 in_bad,
  input  logic [QA-1:0]        spod,
  input  logic [QA-1:0]        dpod,
  input  logic [QB-1:0]        srack_loc,
  input  logic [QB-1:0]        drack_loc,
  input  logic [HW-1:0]        dpos,
  input  logic [KW-1:0]        k,
  input  logic [HW-1:0]        half,
  input  logic [KSQW-1:0]      ksq,
  output logic                 out_valid,
  output fth_pkg::route_t      out_route
);

  localparam int HW1 = HW + 1;
  localparam int PPW = 2 * HW;
  localparam int PKW = QA + KW;
  localparam int WW  = (2 * KW + 2 > fth_pkg::SWITCH_W) ? 2 * KW + 2 : fth_pkg::SWITCH_W;
  localparam int SWW = fth_pkg::SWITCH_W;

  // stage 1
  logic           v1, bad1, same_pod1, same_rack1;
  logic [PKW-1:0] spodk1, dpodk1;
  logic [QB-1:0]  rs1, rd1;
  logic [HW-1:0]  dpos1, agg1;
  logic [HW1-1:0] agg_sum;
  logic [HW-1:0]  agg_n;

  // stage 2
  logic           v2, bad2, same_pod2, same_rack2;
  logic [WW-1:0]  srack2, drack2, aggs2, aggd2;
  logic [HW-1:0]  cidx2;
  logic [PPW-1:0] aghalf2;
  logic [HW1-1:0] c_sum;
  logic [HW-1:0]  c_n;

  // stage 3
  logic [WW-1:0]       core_n;
  fth_pkg::route_t     route_n;

  // Rack switch number mod k/2 is its rack offset, so the sum stays below k.
  assign agg_sum = HW1'(srack_loc) + HW1'(dpos);
  assign agg_n   = (agg_sum >= HW1'(half)) ? HW'(agg_sum - HW1'(half)) : HW'(agg_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      bad1       <= in_bad;
      same_pod1  <= spod == dpod;
      same_rack1 <= (spod == dpod) && (srack_loc == drack_loc);
      spodk1     <= PKW'(spod) * PKW'(k);
      dpodk1     <= PKW'(dpod) * PKW'(k);
      rs1        <= srack_loc;
      rd1        <= drack_loc;
      dpos1      <= dpos;
      agg1       <= agg_n;
    end
  end

  assign c_sum = HW1'(agg1) + HW1'(dpos1);
  assign c_n   = (c_sum >= HW1'(half)) ? HW'(c_sum - HW1'(half)) : HW'(c_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      bad2       <= bad1;
      same_pod2  <= same_pod1;
      same_rack2 <= same_rack1;
      srack2     <= WW'(spodk1) + WW'(rs1);
      drack2     <= WW'(dpodk1) + WW'(rd1);
      aggs2      <= WW'(spodk1) + WW'(half) + WW'(agg1);
      aggd2      <= WW'(dpodk1) + WW'(half) + WW'(agg1);
      cidx2      <= c_n;
      aghalf2    <= PPW'(agg1) * PPW'(half);
    end
  end

  assign core_n = WW'(ksq) + WW'(aghalf2) + WW'(cidx2);

  always_comb begin
    route_n          = '0;
    route_n.sw[0]    = SWW'(srack2);
    route_n.layer[0] = fth_pkg::LAYER_RACK;
    if (bad2) begin
      route_n.sw  = '0;
      route_n.bad = 1'b1;
    end else if (same_rack2) begin
      route_n.last_idx = fth_pkg::HOP_IDX_W'(0);
    end else if (same_pod2) begin
      route_n.sw[1]    = SWW'(aggs2);
      route_n.layer[1] = fth_pkg::LAYER_AGG;
      route_n.sw[2]    = SWW'(drack2);
      route_n.layer[2] = fth_pkg::LAYER_RACK;
      route_n.last_idx = fth_pkg::HOP_IDX_W'(2);
    end else begin
      route_n.sw[1]    = SWW'(aggs2);
      route_n.layer[1] = fth_pkg::LAYER_AGG;
      route_n.sw[2]    = SWW'(core_n);
      route_n.layer[2] = fth_pkg::LAYER_CORE;
      route_n.sw[3]    = SWW'(aggd2);
      route_n.layer[3] = fth_pkg::LAYER_AGG;
      route_n.sw[4]    = SWW'(drack2);
      route_n.layer[4] = fth_pkg::LAYER_RACK;
      route_n.last_idx = fth_pkg::HOP_IDX_W'(4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      out_route <= route_n;
    end
  end

endmodule

// ----- src/fth_serial.sv -----
// Holds one finished route and sends it out one hop per cycle.
// Depends on fth_pkg for route_t and hop_t.
module fth_serial (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  fth_pkg::route_t in_route,
  output logic            adv,
  output logic            strobe,
  output fth_pkg::hop_t   hop
);

  logic                               v;
  fth_pkg::route_t                    rt;
  logic [fth_pkg::HOP_IDX_W-1:0]      idx;

  // Free when empty or when the final hop goes out this cycle.
  assign adv = !v || (idx == rt.last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      v   <= 1'b0;
      idx <= '0;
    end else if (adv) begin
      v   <= in_valid;
      idx <= '0;
    end else begin
      idx <= idx + fth_pkg::HOP_IDX_W'(1);
    end
    if (adv) begin
      rt <= in_route;
    end
  end

  assign strobe            = v;
  assign hop.switch_number = rt.sw[idx];
  assign hop.hop_index     = idx;
  assign hop.hop_layer     = rt.layer[idx];
  assign hop.last_hop      = idx == rt.last_idx;
  assign hop.bad_host      = rt.bad;

endmodule

// ----- src/fat_tree_route_hops_core.sv -----
// Top level: deterministic hop list through a k-ary fat tree.
// Depends on fth_pkg, fth_cfg, fth_div_pipe, fth_route and fth_serial.
//
//  channel  direction  handshake            fields
//  input    in         start / busy         source_host, destination_host
//  result   out        strobe, one cycle    switch_number, hop_index, hop_layer,
//                                           last_hop, bad_host
//  config   in         cfg_we               cfg_data (tree arity)
//
// An item runs through an input register, log2(MAX_ARITY) divider stages for
// pod, log2(MAX_ARITY/2) stages for rack and position, and three stages that
// form switch numbers. The output stage sends one hop per cycle, and a route
// has 1, 3 or 5 hops; busy holds the whole pipeline while a route still has
// hops to send, and in the cycle after a config write while the host count
// updates.
// Reset is synchronous and clears all valid bits; arity returns to 4.
module fat_tree_route_hops_core #(
  parameter int MAX_ARITY = fth_pkg::MAX_ARITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [fth_pkg::HOST_W-1:0]            source_host,
  input  logic [fth_pkg::HOST_W-1:0]            destination_host,
  input  logic                                  cfg_we,
  input  logic [fth_pkg::ARITY_CFG_W-1:0]       cfg_data,
  output logic                                  strobe,
  output logic [fth_pkg::SWITCH_W-1:0]          switch_number,
  output logic [fth_pkg::HOP_IDX_W-1:0]         hop_index,
  output logic [fth_pkg::LAYER_W-1:0]           hop_layer,
  output logic                                  last_hop,
  output logic                                  bad_host
);

  localparam int KW   = $clog2(MAX_ARITY + 1);
  localparam int HW   = $clog2(MAX_ARITY / 2 + 1);
  localparam int PPW  = 2 * HW;
  localparam int KSQW = 2 * KW;
  localparam int HSW  = KW + PPW;
  localparam int QA   = $clog2(MAX_ARITY);
  localparam int QB   = $clog2(MAX_ARITY / 2);
  localparam int HCW  = (HSW > fth_pkg::HOST_W) ? HSW : fth_pkg::HOST_W;

  logic [KW-1:0]   cfg_k;
  logic [HW-1:0]   cfg_half;
  logic [PPW-1:0]  cfg_per_pod;
  logic [KSQW-1:0] cfg_ksq;
  logic [HSW-1:0]  cfg_hosts;
  logic            settling;

  logic            adv;
  logic            accept;

  logic                       v0, bad0;
  logic [fth_pkg::HOST_W-1:0] host0 [2];

  logic            va;
  logic [QA-1:0]   quo_a [2];
  logic [PPW-1:0]  rem_a [2];
  logic            side_a;

  logic                 vb;
  logic [QB-1:0]        quo_b [2];
  logic [HW-1:0]        rem_b [2];
  logic [2*QA:0]        side_b;

  logic            vr;
  fth_pkg::route_t route;
  fth_pkg::hop_t   hop;

  fth_cfg #(.MAX_ARITY(MAX_ARITY)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .k        (cfg_k),
    .half     (cfg_half),
    .per_pod  (cfg_per_pod),
    .ksq      (cfg_ksq),
    .hosts    (cfg_hosts),
    .settling (settling)
  );

  assign busy   = !adv || settling;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= accept;
    end
    if (adv) begin
      host0[0] <= source_host;
      host0[1] <= destination_host;
      bad0     <= (HCW'(source_host) >= HCW'(cfg_hosts)) ||
                  (HCW'(destination_host) >= HCW'(cfg_hosts));
    end
  end

  // host / (k/2)^2 gives pod, remainder is the host's place in the pod
  fth_div_pipe #(.NW(fth_pkg::HOST_W), .DW(PPW), .QW(QA), .SW(1)) u_div_pod (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v0),
    .in_num    (host0),
    .divisor   (cfg_per_pod),
    .in_side   (bad0),
    .out_valid (va),
    .out_quo   (quo_a),
    .out_rem   (rem_a),
    .out_side  (side_a)
  );

  // place in pod / (k/2) gives rack and position in rack
  fth_div_pipe #(.NW(PPW), .DW(HW), .QW(QB), .SW(2 * QA + 1)) u_div_rack (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (va),
    .in_num    (rem_a),
    .divisor   (cfg_half),
    .in_side   ({side_a, quo_a[0], quo_a[1]}),
    .out_valid (vb),
    .out_quo   (quo_b),
    .out_rem   (rem_b),
    .out_side  (side_b)
  );

  fth_route #(.MAX_ARITY(MAX_ARITY)) u_route (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vb),
    .in_bad    (side_b[2*QA]),
    .spod      (side_b[2*QA-1:QA]),
    .dpod      (side_b[QA-1:0]),
    .srack_loc (quo_b[0]),
    .drack_loc (quo_b[1]),
    .dpos      (rem_b[1]),
    .k         (cfg_k),
    .half      (cfg_half),
    .ksq       (cfg_ksq),
    .out_valid (vr),
    .out_route (route)
  );

  fth_serial u_serial (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vr),
    .in_route (route),
    .adv      (adv),
    .strobe   (strobe),
    .hop      (hop)
  );

  assign switch_number = hop.switch_number;
  assign hop_index     = hop.hop_index;
  assign hop_layer     = hop.hop_layer;
  assign last_hop      = hop.last_hop;
  assign bad_host      = hop.bad_host;

  a_hold_mid_route: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_hop |-> busy)
    else $error("input taken while a route still has hops to send");

  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    strobe && bad_host |-> last_hop && hop_index == '0)
    else $error("bad host result is not a single hop");

  a_hop_step: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_hop |=> strobe && hop_index == $past(hop_index) + 3'd1)
    else $error("route hops not sent in consecutive cycles");

  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> busy)
    else $error("input taken before host count updated");

endmodule
